>>> design/lph_pkg.sv
`default_nettype none

package lph_pkg;

    localparam int PROBE_SUM_W = 15;
    localparam int LIVE_W      = 8;
    localparam int KEY_W       = 64;
    localparam int RECORD_W    = 32;
    localparam int PROBE_W     = 8;
    localparam int MOD_W       = 8;
    localparam logic [MOD_W-1:0] MOD_RESET = 8'd97;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } lph_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DELETED   = 2'd2,
        ST_FULL      = 2'd3
    } lph_status_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_DIV_MOD,
        H_DIV_SLOTS,
        H_DONE
    } lph_hstate_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_DONE
    } lph_state_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [KEY_W-1:0]    key_chars;
        logic [RECORD_W-1:0] record_payload;
    } lph_req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [RECORD_W-1:0]    found_payload;
        logic [PROBE_W-1:0]     probe_count;
        logic [PROBE_SUM_W-1:0] probe_sum;
        logic [LIVE_W-1:0]      live_count;
    } lph_rsp_t;

    typedef struct packed {
        logic                   written;
        logic                   deleted;
        logic                   live;
        logic [PROBE_SUM_W-1:0] probes;
    } lph_meta_t;

    typedef struct packed {
        logic      meta_we;
        logic      data_we;
        lph_meta_t meta;
    } lph_wr_t;

endpackage

`default_nettype wire

>>> design/lph_hash.sv
`default_nettype none

module lph_hash import lph_pkg::*; #(
    parameter int TABLE_SLOTS = 128,
    parameter int NAME_CHARS  = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [8*NAME_CHARS-1:0]        key,
    input  wire logic [MOD_W-1:0]               modulus,
    output logic                                done,
    output logic [$clog2(TABLE_SLOTS)-1:0]      home
);

    localparam int SW  = 8 + $clog2(NAME_CHARS);
    localparam int IW  = $clog2(TABLE_SLOTS);
    localparam int DVW = (IW + 1 > MOD_W) ? IW + 1 : MOD_W;
    localparam int CW  = $clog2(SW);

    lph_hstate_t     state_reg, state_next;
    logic [SW-1:0]   dvd_reg, dvd_next;
    logic [DVW-1:0]  rem_reg, rem_next;
    logic [DVW-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic [SW-1:0]   sum;
    logic [DVW:0]    trial;
    logic [DVW:0]    diff;
    logic [DVW-1:0]  rem_step;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            sum = sum + SW'(key[8*i +: 8]);
        end
    end

    assign trial    = {rem_reg, dvd_reg[SW-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_step = (trial >= {1'b0, dvs_reg}) ? diff[DVW-1:0] : trial[DVW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = sum;
                    rem_next   = '0;
                    dvs_next   = (modulus == '0) ? DVW'(1) : DVW'(modulus);
                    cnt_next   = '0;
                    state_next = H_DIV_MOD;
                end
            end
            H_DIV_MOD:
            begin
                dvd_next = dvd_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SW - 1))
                begin
                    cnt_next   = '0;
                    state_next = H_DIV_SLOTS;
                end
            end
            H_DIV_SLOTS:
            begin
                if (rem_reg >= DVW'(TABLE_SLOTS))
                begin
                    rem_next = rem_reg - DVW'(TABLE_SLOTS);
                end
                else
                begin
                    state_next = H_DONE;
                end
            end
            H_DONE:
            begin
                done       = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    assign home = rem_reg[IW-1:0];

endmodule

`default_nettype wire

>>> design/lph_store.sv
`default_nettype none

module lph_store import lph_pkg::*; #(
    parameter int TABLE_SLOTS = 128,
    parameter int KW          = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    input  wire lph_wr_t                        wr,
    input  wire logic [KW-1:0]                  wr_name,
    input  wire logic [RECORD_W-1:0]            wr_record,
    output lph_meta_t                           q_meta,
    output logic [KW-1:0]                       q_name,
    output logic [RECORD_W-1:0]                 q_record,
    output logic                                busy
);

    localparam int IW = $clog2(TABLE_SLOTS);

    lph_meta_t           meta_mem [TABLE_SLOTS];
    logic [KW-1:0]       name_mem [TABLE_SLOTS];
    logic [RECORD_W-1:0] rec_mem  [TABLE_SLOTS];

    logic [IW-1:0] clr_addr_reg;
    logic          busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == IW'(TABLE_SLOTS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            meta_mem[clr_addr_reg] <= '0;
        end
        else if (wr.meta_we)
        begin
            meta_mem[wr_addr] <= wr.meta;
        end
        if (rd_en)
        begin
            q_meta <= meta_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            name_mem[wr_addr] <= wr_name;
            rec_mem[wr_addr]  <= wr_record;
        end
        if (rd_en)
        begin
            q_name   <= name_mem[rd_addr];
            q_record <= rec_mem[rd_addr];
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> design/linear_probe_hash_table_top.sv
// channel | direction | handshake           | word
// req     | in        | req_valid/req_stall | lph_req_t: opcode, key_chars, record_payload
// rsp     | out       | rsp_valid/rsp_stall | lph_rsp_t: status, payload, probe stats
// cfg     | in        | cfg_we              | hash_modulus
// One request at a time: accept, hash start, bit-serial division of the key sum by
// hash_modulus, wrap by repeated subtraction of TABLE_SLOTS, hash done, a linear
// probe scan of the slot memory, then the output register.
// After reset a clearing pass sweeps the slot state; req_stall stays high until it
// ends. A stalled response holds in the output register while the next request is
// taken and worked on.
`default_nettype none

module linear_probe_hash_table_top import lph_pkg::*; #(
    parameter int TABLE_SLOTS = 128,
    parameter int NAME_CHARS  = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire lph_req_t         req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output lph_rsp_t              rsp,
    input  wire logic             cfg_we,
    input  wire logic [MOD_W-1:0] cfg_wdata
);

    localparam int KW = 8 * NAME_CHARS;
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int NW = IW + 1;

    lph_state_t          state_reg, state_next;
    logic [MOD_W-1:0]    mod_reg;
    logic [1:0]          op_reg, op_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [RECORD_W-1:0] pay_reg, pay_next;
    logic [IW-1:0]       ptr_reg, ptr_next;
    logic [IW-1:0]       chk_reg, chk_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                have_reg, have_next;
    lph_rsp_t            res_reg, res_next;
    logic [PROBE_SUM_W-1:0] total_reg, total_next;
    logic [LIVE_W-1:0]   live_reg, live_next;
    lph_rsp_t            out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic          accept;
    logic          hash_start;
    logic          hash_done;
    logic [IW-1:0] home;
    logic          rd_en;
    lph_wr_t       wr;
    lph_meta_t     q_meta;
    logic [KW-1:0] q_name;
    logic [RECORD_W-1:0] q_record;
    logic          busy;
    logic [NW-1:0] n_inc;
    logic          hit;

    lph_hash #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .NAME_CHARS (NAME_CHARS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key_reg),
        .modulus(mod_reg),
        .done   (hash_done),
        .home   (home)
    );

    lph_store #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .KW         (KW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (ptr_reg),
        .wr_addr  (chk_reg),
        .wr       (wr),
        .wr_name  (key_reg),
        .wr_record(pay_reg),
        .q_meta   (q_meta),
        .q_name   (q_name),
        .q_record (q_record),
        .busy     (busy)
    );

    assign req_stall = busy || (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign n_inc     = n_reg + 1'b1;
    assign hit       = q_meta.written && (q_name == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mod_reg       <= MOD_RESET;
            total_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            if (cfg_we)
            begin
                mod_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        ptr_reg <= ptr_next;
        chk_reg <= chk_next;
        n_reg   <= n_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        ptr_next       = ptr_reg;
        chk_next       = chk_reg;
        n_next         = n_reg;
        have_next      = have_reg;
        res_next       = res_reg;
        total_next     = total_reg;
        live_next      = live_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        hash_start     = 1'b0;
        rd_en          = 1'b0;
        wr             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.opcode;
                    key_next = req.key_chars[KW-1:0];
                    pay_next = req.record_payload;
                    res_next = '0;
                    res_next.status = ST_NOT_FOUND;
                    if (req.opcode inside {OP_INSERT, OP_SEARCH, OP_DELETE})
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                hash_start = 1'b1;
                if (hash_done)
                begin
                    ptr_next   = home;
                    n_next     = '0;
                    have_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en     = 1'b1;
                have_next = 1'b1;
                chk_next  = ptr_reg;
                ptr_next  = (ptr_reg == IW'(TABLE_SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
                if (have_reg)
                begin
                    n_next = n_inc;
                    if (op_reg == OP_INSERT)
                    begin
                        if (!q_meta.live && !q_meta.deleted)
                        begin
                            wr.meta_we          = 1'b1;
                            wr.data_we          = 1'b1;
                            wr.meta.written     = 1'b1;
                            wr.meta.live        = 1'b1;
                            wr.meta.probes      = PROBE_SUM_W'(n_inc);
                            total_next          = total_reg + PROBE_SUM_W'(n_inc);
                            live_next           = live_reg + 1'b1;
                            res_next.status     = ST_OK;
                            res_next.probe_count = PROBE_W'(n_inc);
                            state_next          = S_DONE;
                        end
                        else if (n_inc == NW'(TABLE_SLOTS))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                    end
                    else if (hit)
                    begin
                        if (q_meta.deleted)
                        begin
                            res_next.status = ST_DELETED;
                        end
                        else if (op_reg == OP_SEARCH)
                        begin
                            res_next.status        = ST_OK;
                            res_next.found_payload = q_record;
                        end
                        else
                        begin
                            wr.meta_we      = 1'b1;
                            wr.meta.written = 1'b1;
                            wr.meta.deleted = 1'b1;
                            total_next      = total_reg - q_meta.probes;
                            live_next       = live_reg - 1'b1;
                            res_next.status = ST_OK;
                        end
                        state_next = S_DONE;
                    end
                    else if (n_inc == NW'(TABLE_SLOTS))
                    begin
                        res_next.status = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next            = res_reg;
                    out_next.probe_sum  = total_reg;
                    out_next.live_count = live_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

>>> design/lph_check.sv
`default_nettype none

module lph_check import lph_pkg::*; (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_stall,
    input wire logic     rsp_valid,
    input wire logic     rsp_stall,
    input wire lph_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    a_payload_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.found_payload == '0)
        else $error("payload returned on failed request");

    a_probe_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.probe_count == '0)
        else $error("probe count on failed request");

endmodule

bind linear_probe_hash_table_top lph_check u_lph_check (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lph_pkg::*;

    localparam int SLOTS      = 128;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    lph_req_t   req;
    logic       rsp_valid;
    logic       rsp_stall;
    lph_rsp_t   rsp;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    linear_probe_hash_table_top #(.TABLE_SLOTS(SLOTS), .NAME_CHARS(8)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // shadow table
    logic [7:0]  modulus;
    logic [63:0] name_at [SLOTS];
    logic [31:0] record_at [SLOTS];
    logic [7:0]  probes_at [SLOTS];
    bit          written_at [SLOTS];
    bit          deleted_at [SLOTS];
    logic [14:0] probe_total;
    logic [7:0]  live_total;

    lph_req_t pending_words[$];
    lph_rsp_t expected_words[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_recv;
    bit       failed;
    int       quiet_cycles;
    logic [63:0] key_pool[$];

    function automatic void add_pending(lph_req_t r);
        pending_words = {pending_words, r};
    endfunction

    function automatic int home_of(logic [63:0] key);
        int sum;
        int m;
        sum = 0;
        m = (modulus == 0) ? 1 : modulus;
        for (int i = 0; i < 8; i++)
            sum += key[8*i +: 8];
        return (sum % m) % SLOTS;
    endfunction

    function automatic int match_slot(logic [63:0] key);
        int idx;
        idx = home_of(key);
        for (int n = 0; n < SLOTS; n++) begin
            if (written_at[idx] && name_at[idx] == key)
                return idx;
            idx = (idx + 1) % SLOTS;
        end
        return -1;
    endfunction

    function automatic lph_rsp_t apply_request(lph_req_t r);
        lph_rsp_t o;
        int idx;
        int n;
        int s;
        o = '0;
        o.status = ST_NOT_FOUND;
        if (r.opcode == OP_INSERT) begin
            idx = home_of(r.key_chars);
            n = 0;
            while (n < SLOTS && (probes_at[idx] != 0 || deleted_at[idx])) begin
                idx = (idx + 1) % SLOTS;
                n++;
            end
            if (n >= SLOTS) begin
                o.status = ST_FULL;
            end
            else begin
                o.probe_count = 8'(n + 1);
                name_at[idx] = r.key_chars;
                record_at[idx] = r.record_payload;
                probes_at[idx] = 8'(n + 1);
                written_at[idx] = 1;
                probe_total += 15'(n + 1);
                live_total += 8'd1;
                o.status = ST_OK;
            end
        end
        else if (r.opcode == OP_SEARCH || r.opcode == OP_DELETE) begin
            s = match_slot(r.key_chars);
            if (s >= 0) begin
                if (deleted_at[s]) begin
                    o.status = ST_DELETED;
                end
                else if (r.opcode == OP_SEARCH) begin
                    o.status = ST_OK;
                    o.found_payload = record_at[s];
                end
                else begin
                    probe_total -= 15'(probes_at[s]);
                    live_total -= 8'd1;
                    probes_at[s] = 0;
                    deleted_at[s] = 1;
                    o.status = ST_OK;
                end
            end
        end
        o.probe_sum = probe_total;
        o.live_count = live_total;
        return o;
    endfunction

    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        int len;
        k = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            k[8*i +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    function automatic lph_req_t make_request(logic [1:0] op, logic [63:0] key,
                                              logic [31:0] data);
        lph_req_t r;
        r.opcode = op;
        r.key_chars = key;
        r.record_payload = data;
        return r;
    endfunction

    // queue a random request, mostly on keys already seen
    task automatic queue_random();
        logic [63:0] key;
        int pick;
        pick = $urandom_range(0, 99);
        if (key_pool.size() == 0 || pick < 30) begin
            key = (pick < 3) ? {$urandom, $urandom} : fresh_key();
            key_pool = {key_pool, key};
        end
        else begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        pick = $urandom_range(0, 99);
        add_pending(make_request(
            (pick < 45) ? OP_INSERT : (pick < 75) ? OP_SEARCH :
            (pick < 97) ? OP_DELETE : OP_UNUSED, key, $urandom));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_words.size() != 0 || req_valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_modulus(logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        modulus = value;
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else begin
            if (req_valid && !req_stall) begin
                expected_words = {expected_words, apply_request(req)};
            end
            if ((!req_valid || !req_stall)) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_valid <= 1'b1;
                    req <= pending_words.pop_front();
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        lph_rsp_t want;
        if (!rst_n) begin
            rsp_stall <= 1'b1;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: %p", rsp);
                    failed = 1;
                end
                else begin
                    want = expected_words.pop_front();
                    if (rsp.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, rsp.status);
                        failed = 1;
                    end
                    if (rsp.found_payload !== want.found_payload) begin
                        $error("found_payload expected %h got %h",
                               want.found_payload, rsp.found_payload);
                        failed = 1;
                    end
                    if (rsp.probe_count !== want.probe_count) begin
                        $error("probe_count expected %0d got %0d",
                               want.probe_count, rsp.probe_count);
                        failed = 1;
                    end
                    if (rsp.probe_sum !== want.probe_sum) begin
                        $error("probe_sum expected %0d got %0d", want.probe_sum, rsp.probe_sum);
                        failed = 1;
                    end
                    if (rsp.live_count !== want.live_count) begin
                        $error("live_count expected %0d got %0d",
                               want.live_count, rsp.live_count);
                        failed = 1;
                    end
                end
            end
            if (hold_recv > 0) begin
                hold_recv <= hold_recv - 1;
                rsp_stall <= 1'b1;
            end
            else begin
                rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] k;
        failed = 0;
        quiet_cycles = 0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        modulus = MOD_RESET;
        probe_total = '0;
        live_total = '0;
        for (int i = 0; i < SLOTS; i++) begin
            probes_at[i] = 0;
            written_at[i] = 0;
            deleted_at[i] = 0;
        end
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b1;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, duplicates, tombstones, unused opcode
        k = 64'h0000_0000_0000_0041;
        add_pending(make_request(OP_SEARCH, k, 32'h0));
        add_pending(make_request(OP_DELETE, k, 32'h0));
        add_pending(make_request(OP_INSERT, k, 32'hFFFF_FFFF));
        add_pending(make_request(OP_INSERT, k, 32'h1234_5678));
        add_pending(make_request(OP_SEARCH, k, 32'h0));
        add_pending(make_request(OP_DELETE, k, 32'h0));
        add_pending(make_request(OP_SEARCH, k, 32'h0));
        add_pending(make_request(OP_DELETE, k, 32'h0));
        add_pending(make_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
        add_pending(make_request(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
        add_pending(make_request(OP_INSERT, 64'h0, 32'hA5A5_A5A5));
        add_pending(make_request(OP_SEARCH, 64'h0, 32'h0));
        add_pending(make_request(OP_UNUSED, 64'h0, 32'hFFFF_FFFF));
        add_pending(make_request(OP_INSERT, 64'h0000_0000_0000_4100, 32'h7));
        add_pending(make_request(OP_SEARCH, 64'h0000_0000_0000_4100, 32'h0));
        wait_drained();

        // modulus 1: everything homes at slot 0, fill the table past full
        write_modulus(8'd1);
        for (int i = 0; i < SLOTS + 4; i++)
            add_pending(make_request(OP_INSERT, fresh_key(), $urandom));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 400;
        wait_drained();
        k = 64'h0;
        add_pending(make_request(OP_SEARCH, 64'h1234, 32'h0));
        add_pending(make_request(OP_DELETE, 64'h0, 32'h0));
        add_pending(make_request(OP_INSERT, 64'h55, 32'h1));
        wait_drained();

        // modulus 0 and 128, then random phases with assorted moduli
        write_modulus(8'd0);
        add_pending(make_request(OP_SEARCH, 64'h99, 32'h0));
        wait_drained();
        write_modulus(8'd128);
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int i = 0; i < 50; i++)
                queue_random();
            wait_drained();
            write_modulus((p == 1) ? 8'd255 : 8'($urandom_range(1, 128)));
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 100; i++)
            queue_random();
        wait_drained();

        if (!failed)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
